@@ hw/rtl/vdss_pkg.sv @@
package vdss_pkg;

    localparam int DEFAULT_TABLE_ROWS = 16;
    localparam int ROW_SHIFT          = 12;
    localparam int INTEN_SHIFT        = 4;
    localparam int FRAC_BITS          = 16;
    localparam int QUEUE_DEPTH        = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 63;
    localparam int COMP_W      = 21;

    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_MODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_VECTOR    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VIEW_VECTOR     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMBIENT_LEVEL   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLASH_THRESHOLD = 3'd4;

    localparam logic [1:0] MODE_DIFFUSE = 2'd0;
    localparam logic [1:0] MODE_SPEC    = 2'd1;
    localparam logic [1:0] MODE_COMB    = 2'd2;

    typedef enum logic [1:0] {
        CLS_DIFFUSE,
        CLS_AWAY,
        CLS_SPEC,
        CLS_COMB
    } shade_class_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [62:0]        light;
        logic [62:0]        view;
        logic signed [31:0] ambient;
        logic signed [31:0] flash;
    } shade_cfg_t;

    typedef struct packed {
        shade_class_t       cls;
        logic signed [31:0] nl;
        logic signed [31:0] nv;
        logic signed [31:0] lv;
    } vdss_entry_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = 32'(v);
        return r;
    endfunction

endpackage

@@ hw/rtl/vdss_front.sv @@
module vdss_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vdss_pkg::shade_cfg_t cfg,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   normal_x,
    input  logic signed [31:0]   normal_y,
    input  logic signed [31:0]   normal_z,
    input  logic                 q_full,
    output logic                 push,
    output vdss_pkg::vdss_entry_t push_entry
);
    import vdss_pkg::*;

    logic signed [COMP_W-1:0] l_c [3];
    logic signed [COMP_W-1:0] v_c [3];
    logic signed [31:0]       n_c [3];

    logic                     f1_valid_reg;
    logic signed [52:0]       ln_reg [3];
    logic signed [52:0]       vn_reg [3];
    logic signed [41:0]       lv_reg [3];

    logic                     f2_valid_reg;
    vdss_entry_t              f2_entry_reg;
    vdss_entry_t              f2_entry_next;

    logic                     adv_f1;
    logic                     adv_f2;

    logic signed [54:0]       ln_sum;
    logic signed [54:0]       vn_sum;
    logic signed [43:0]       lv_sum;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            l_c[i] = signed'(cfg.light[i*COMP_W +: COMP_W]);
            v_c[i] = signed'(cfg.view[i*COMP_W +: COMP_W]);
        end
        n_c[0] = normal_x;
        n_c[1] = normal_y;
        n_c[2] = normal_z;
    end

    assign adv_f2     = !f2_valid_reg || !q_full;
    assign adv_f1     = !f1_valid_reg || adv_f2;
    assign in_stall   = !adv_f1;
    assign push       = f2_valid_reg && !q_full;
    assign push_entry = f2_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_f1)
                f1_valid_reg <= in_valid;
            if (adv_f2)
                f2_valid_reg <= f1_valid_reg;
        end
    end

    // component products
    always_ff @(posedge clk)
    begin
        if (adv_f1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ln_reg[i] <= l_c[i] * n_c[i];
                vn_reg[i] <= v_c[i] * n_c[i];
                lv_reg[i] <= l_c[i] * v_c[i];
            end
        end
    end

    always_comb
    begin
        ln_sum = 55'(ln_reg[0]) + 55'(ln_reg[1]) + 55'(ln_reg[2]);
        vn_sum = 55'(vn_reg[0]) + 55'(vn_reg[1]) + 55'(vn_reg[2]);
        lv_sum = 44'(lv_reg[0]) + 44'(lv_reg[1]) + 44'(lv_reg[2]);

        f2_entry_next.nl = sat32(64'(ln_sum >>> FRAC_BITS));
        f2_entry_next.nv = sat32(64'(vn_sum >>> FRAC_BITS));
        f2_entry_next.lv = 32'(lv_sum >>> FRAC_BITS);

        unique case (cfg.mode)
            MODE_DIFFUSE: f2_entry_next.cls = CLS_DIFFUSE;
            MODE_SPEC:    f2_entry_next.cls = CLS_SPEC;
            default:      f2_entry_next.cls = CLS_COMB;
        endcase
        if (cfg.mode != MODE_DIFFUSE && f2_entry_next.nl < 0)
            f2_entry_next.cls = CLS_AWAY;
    end

    always_ff @(posedge clk)
    begin
        if (adv_f2)
            f2_entry_reg <= f2_entry_next;
    end

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> f1_valid_reg)
        else $error("accepted request did not enter the product stage");

    a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (f2_valid_reg && q_full) |=> (f2_valid_reg && $stable(f2_entry_reg)))
        else $error("blocked dot product stage lost its request");

endmodule

@@ hw/rtl/vdss_queue.sv @@
module vdss_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  vdss_pkg::vdss_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  q_valid,
    output vdss_pkg::vdss_entry_t q_entry
);
    import vdss_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    vdss_entry_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && q_valid))
            count_next = count_reg + 1'b1;
        else if (!push && pop && q_valid)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop && q_valid)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into a full queue");

endmodule

@@ hw/rtl/vdss_back.sv @@
module vdss_back #(
    parameter int TABLE_ROWS = vdss_pkg::DEFAULT_TABLE_ROWS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vdss_pkg::shade_cfg_t  cfg,
    input  logic                  q_valid,
    input  vdss_pkg::vdss_entry_t q_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [31:0]    shade,
    output logic signed [27:0]    intensity
);
    import vdss_pkg::*;

    localparam logic signed [31:0] LIMIT = 32'(TABLE_ROWS << ROW_SHIFT);

    logic               b1_valid_reg;
    shade_class_t       b1_cls_reg;
    logic signed [31:0] b1_nl_reg;
    logic signed [31:0] b1_lv_reg;
    logic signed [63:0] b1_prod_reg;

    logic               b2_valid_reg;
    shade_class_t       b2_cls_reg;
    logic signed [31:0] b2_nl_reg;
    logic signed [31:0] b2_s_reg;
    logic signed [31:0] b2_s_next;

    logic               out_valid_reg;
    logic signed [31:0] shade_reg;
    logic signed [27:0] inten_reg;
    logic signed [31:0] shade_next;
    logic signed [31:0] t_next;

    logic               adv_b1;
    logic               adv_b2;
    logic               adv_out;

    logic signed [31:0] nv2;
    logic signed [31:0] mul_a;
    logic signed [31:0] f;
    logic signed [31:0] f_sel;
    logic signed [31:0] s0;
    logic signed [31:0] nl_pos;
    logic signed [63:0] spec_sum;

    assign adv_out   = !out_valid_reg || !out_stall;
    assign adv_b2    = !b2_valid_reg || adv_out;
    assign adv_b1    = !b1_valid_reg || adv_b2;
    assign pop       = q_valid && adv_b1;
    assign out_valid = out_valid_reg;
    assign shade     = shade_reg;
    assign intensity = inten_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_b1)
                b1_valid_reg <= q_valid;
            if (adv_b2)
                b2_valid_reg <= b1_valid_reg;
            if (adv_out)
                out_valid_reg <= b2_valid_reg;
        end
    end

    // phong product
    always_comb
    begin
        nv2   = sat32(64'(q_entry.nv) + 64'(q_entry.nv));
        mul_a = (q_entry.cls == CLS_COMB) ? q_entry.nv : nv2;
    end

    always_ff @(posedge clk)
    begin
        if (adv_b1)
        begin
            b1_cls_reg  <= q_entry.cls;
            b1_nl_reg   <= q_entry.nl;
            b1_lv_reg   <= q_entry.lv;
            b1_prod_reg <= mul_a * q_entry.nl;
        end
    end

    always_comb
    begin
        f         = sat32(b1_prod_reg >>> FRAC_BITS);
        f_sel     = (b1_cls_reg == CLS_COMB) ? sat32(64'(f) + 64'(f)) : f;
        b2_s_next = sat32(64'(f_sel) - 64'(b1_lv_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv_b2)
        begin
            b2_cls_reg <= b1_cls_reg;
            b2_nl_reg  <= b1_nl_reg;
            b2_s_reg   <= b2_s_next;
        end
    end

    // final sum and clamp
    always_comb
    begin
        s0       = (b2_s_reg < cfg.flash) ? 32'sd0 : b2_s_reg;
        nl_pos   = (b2_nl_reg < 0) ? 32'sd0 : b2_nl_reg;
        spec_sum = 64'(s0) + 64'(cfg.ambient);
        if (b2_cls_reg == CLS_COMB)
            spec_sum = spec_sum + 64'(b2_nl_reg);
        case (b2_cls_reg)
            CLS_DIFFUSE:
            begin
                t_next     = sat32(64'(nl_pos) + 64'(cfg.ambient));
                shade_next = t_next >>> INTEN_SHIFT;
            end
            CLS_AWAY:
            begin
                t_next     = cfg.ambient;
                shade_next = t_next >>> INTEN_SHIFT;
            end
            default:
            begin
                t_next = sat32(spec_sum);
                if (t_next >= LIMIT)
                    t_next = LIMIT - 32'sd1;
                shade_next = t_next;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            shade_reg <= shade_next;
            inten_reg <= 28'(t_next >>> INTEN_SHIFT);
        end
    end

    a_spec_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (adv_out && b2_valid_reg && (b2_cls_reg == CLS_SPEC || b2_cls_reg == CLS_COMB))
        |=> (shade_reg < LIMIT))
        else $error("specular shade not clamped below the table limit");

    a_stall_holds_b2: assert property (@(posedge clk) disable iff (!rst_n)
        (b2_valid_reg && out_valid_reg && out_stall) |=> (b2_valid_reg && $stable(b2_s_reg)))
        else $error("specular stage changed while the output was blocked");

endmodule

@@ hw/rtl/vertex_diffuse_specular_shade.sv @@
// Per-vertex diffuse and specular shading in 16.16 fixed point. One normal request is taken
// every cycle while in_stall is low and gives one shade and intensity. The front computes the
// three dot products in two stages (component multipliers, then sum, shift and saturate, with
// lv truncated instead) and classifies the request; a four-entry queue feeds the back, which
// runs the phong term through one 32x32 multiplier stage, a shift/saturate stage and the final
// add and clamp into the output register. Every stage is registered, so throughput is one per
// cycle while the output is not stalled. Configuration through cfg_we/cfg_index/cfg_data
// must be written only while no request is in flight; the block itself does not enforce it.
module vertex_diffuse_specular_shade #(
    parameter int TABLE_ROWS = vdss_pkg::DEFAULT_TABLE_ROWS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vdss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vdss_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [31:0]                normal_x,
    input  logic signed [31:0]                normal_y,
    input  logic signed [31:0]                normal_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [31:0]                shade,
    output logic signed [27:0]                intensity
);
    import vdss_pkg::*;

    shade_cfg_t  cfg_reg;
    logic        q_full;
    logic        push;
    logic        pop;
    logic        q_valid;
    vdss_entry_t push_entry;
    vdss_entry_t q_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIGHT_MODE:      cfg_reg.mode    <= cfg_data[1:0];
                CFG_LIGHT_VECTOR:    cfg_reg.light   <= cfg_data;
                CFG_VIEW_VECTOR:     cfg_reg.view    <= cfg_data;
                CFG_AMBIENT_LEVEL:   cfg_reg.ambient <= signed'(cfg_data[31:0]);
                CFG_FLASH_THRESHOLD: cfg_reg.flash   <= signed'(cfg_data[31:0]);
                default:             ;
            endcase
        end
    end

    vdss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    vdss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    vdss_back #(
        .TABLE_ROWS (TABLE_ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .shade      (shade),
        .intensity  (intensity)
    );

endmodule
